@@ rtl/swm_pkg.sv @@
// Shared types and constants for the sliding window maximum filter.
package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;
  localparam int WINDOW_RESET   = 3;

  // One queue entry as seen by its neighbors.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
  } swm_cand_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic step;   // item accepted this cycle
    logic first;  // item starts a new sequence: previous contents ignored
    logic shift;  // front entry leaves the window: chain moves one place
    logic flush;  // configuration write: empty the queue
  } swm_ctl_t;

endpackage

@@ rtl/swm_cell.sv @@
// One slot of the candidate queue: value, age and the keep/append decision.
module swm_cell #(
  parameter int AGE_W = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  swm_pkg::swm_ctl_t                     ctl,
  input  logic signed [swm_pkg::DATA_W-1:0]     sample,
  input  swm_pkg::swm_cand_t                    nbr,
  input  logic [AGE_W-1:0]                      nbr_age,
  input  logic                                  prev_keep,
  output swm_pkg::swm_cand_t                    cur,
  output logic [AGE_W-1:0]                      cur_age,
  output swm_pkg::swm_cand_t                    nxt,
  output logic                                  keep
);
  import swm_pkg::*;

  logic                     valid_r;
  logic signed [DATA_W-1:0] value_r;
  logic [AGE_W-1:0]         age_r;
  swm_cand_t                cand_nxt;
  logic [AGE_W-1:0]         age_nxt;
  logic                     src_valid;
  logic signed [DATA_W-1:0] src_value;
  logic [AGE_W-1:0]         src_age;

  always_comb begin
    src_valid = ctl.shift ? nbr.valid : valid_r;
    src_value = ctl.shift ? nbr.value : value_r;
    src_age   = ctl.shift ? nbr_age   : age_r;
    if (ctl.first) begin
      src_valid = 1'b0;
    end
    // Queue is non-increasing, so kept entries always form a prefix.
    keep = src_valid && (src_value >= sample);
    if (keep) begin
      cand_nxt.valid = 1'b1;
      cand_nxt.value = src_value;
      age_nxt        = src_age + AGE_W'(1);
    end else if (prev_keep) begin
      cand_nxt.valid = 1'b1;
      cand_nxt.value = sample;
      age_nxt        = '0;
    end else begin
      cand_nxt.valid = 1'b0;
      cand_nxt.value = sample;
      age_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.flush) begin
      valid_r <= 1'b0;
    end else if (ctl.step) begin
      valid_r <= cand_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      value_r <= cand_nxt.value;
      age_r   <= age_nxt;
    end
  end

  assign cur     = {valid_r, value_r};
  assign cur_age = age_r;
  assign nxt     = cand_nxt;

endmodule

@@ rtl/sliding_window_maximum.sv @@
// Running maximum over the last window_size signed samples; takes one item per
// clock cycle unless the output stalls, and shows the result next cycle in a register.
// The candidate queue is a chain of WINDOW_MAX cells; each cell compares its
// entry with the new sample in parallel, so that one 32-bit compare and the
// neighbor selection set the cycle time. No result is produced until a
// sequence has seen window_size samples. Writing window_size restarts the
// sequence. No clearing pass is needed after reset.
module sliding_window_maximum #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [swm_pkg::DATA_W-1:0] in_sample,
  input  logic                              in_first,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [swm_pkg::DATA_W-1:0] out_window_max,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]         cfg_window_size
);
  import swm_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WW = $clog2(WINDOW_MAX + 1);
  localparam int CW = (WW > CFG_W) ? WW : CFG_W;

  logic [CFG_W-1:0]         window_size_r;
  logic [WW-1:0]            seen_r;
  logic [WW-1:0]            seen_base;
  logic [WW-1:0]            seen_nxt;
  logic [WW-1:0]            win_eff;
  logic [CW-1:0]            ws_ext;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_window_max_r;
  logic                     step;
  logic                     res_valid;
  swm_ctl_t                 ctl;

  swm_cand_t        cur  [WINDOW_MAX];
  swm_cand_t        nxt  [WINDOW_MAX];
  logic [AW-1:0]    age  [WINDOW_MAX];
  logic             keep [WINDOW_MAX];

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;

  // Clamp the window into 1..WINDOW_MAX.
  always_comb begin
    ws_ext = CW'(window_size_r);
    if (ws_ext == '0) begin
      win_eff = WW'(1);
    end else if (ws_ext > CW'(WINDOW_MAX)) begin
      win_eff = WW'(WINDOW_MAX);
    end else begin
      win_eff = WW'(ws_ext);
    end
  end

  always_comb begin
    ctl.step  = step;
    ctl.first = in_first;
    ctl.flush = cfg_valid && cfg_ready;
    // Front entry is the oldest window sample exactly when its age is w-1.
    ctl.shift = !in_first && cur[0].valid && (WW'(age[0]) == win_eff - WW'(1));
  end

  always_comb begin
    seen_base = in_first ? '0 : seen_r;
    seen_nxt  = (seen_base < win_eff) ? seen_base + WW'(1) : seen_base;
    res_valid = (seen_nxt == win_eff);
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cand_t     nbr;
    logic [AW-1:0] nbr_age;
    logic          prev_keep;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign nbr     = '0;
      assign nbr_age = '0;
    end else begin : g_mid
      assign nbr     = cur[i+1];
      assign nbr_age = age[i+1];
    end

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
    end else begin : g_tail
      assign prev_keep = keep[i-1];
    end

    swm_cell #(
      .AGE_W (AW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .sample    (in_sample),
      .nbr       (nbr),
      .nbr_age   (nbr_age),
      .prev_keep (prev_keep),
      .cur       (cur[i]),
      .cur_age   (age[i]),
      .nxt       (nxt[i]),
      .keep      (keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= CFG_W'(WINDOW_RESET);
      seen_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_size_r <= cfg_window_size;
        seen_r        <= '0;
      end else if (step) begin
        seen_r <= seen_nxt;
      end
      if (step) begin
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_window_max_r <= nxt[0].value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_window_max_r;

`ifndef SYNTHESIS
  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= win_eff)
    else $error("seen count exceeds window");

  a_queue_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_r != '0) |-> cur[0].valid)
    else $error("queue empty after a sample was taken");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step))
    else $error("result appeared without an accepted item");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (seen_r == '0) && !cur[0].valid)
    else $error("configuration write did not restart the sequence");
`endif

endmodule

@@ test/swm_checker.sv @@
// Checker for the sliding window maximum filter: predicts each window maximum and compares it.
`timescale 1ns / 1ps
module swm_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [swm_pkg::DATA_W-1:0] in_sample,
  input  logic                              in_first,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [swm_pkg::DATA_W-1:0] out_window_max,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]         cfg_window_size,
  output int                                errors,
  output int                                pending
);
  import swm_pkg::*;

  localparam int DEPTH = WINDOW_MAX_DEF;
  typedef logic signed [DATA_W-1:0] sample_t;

  sample_t          hist [DEPTH];
  sample_t          cand [DEPTH];
  int unsigned      cand_n;
  int unsigned      hist_ptr;
  int unsigned      seen_n;
  logic [CFG_W-1:0] win_reg;
  sample_t          max_expected [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int unsigned span();
    int unsigned w;
    w = win_reg;
    if (w == 0) w = 1;
    if (w > DEPTH) w = DEPTH;
    return w;
  endfunction

  task automatic clear_sequence();
    cand_n   = 0;
    hist_ptr = 0;
    seen_n   = 0;
  endtask

  task automatic drop_head_cand();
    if (cand_n == 0) return;
    for (int i = 0; i + 1 < cand_n; i++) cand[i] = cand[i+1];
    cand_n--;
  endtask

  // One sample through the candidate queue; has is set when a maximum is due.
  task automatic advance_window(input sample_t s, input logic f,
                                output bit has, output sample_t m);
    int unsigned w;
    int unsigned old;
    w = span();
    if (f) clear_sequence();
    if (seen_n >= w) begin
      old = (hist_ptr + DEPTH - w) % DEPTH;
      // oldest sample leaves the window; drop it if it is the current maximum
      if (cand_n > 0 && cand[0] == hist[old]) drop_head_cand();
    end
    while (cand_n > 0 && cand[cand_n-1] < s) cand_n--;
    if (cand_n >= DEPTH) drop_head_cand();
    cand[cand_n] = s;
    cand_n++;
    hist[hist_ptr] = s;
    hist_ptr = (hist_ptr + 1) % DEPTH;
    if (seen_n < w) seen_n++;
    has = (seen_n >= w);
    m   = cand[0];
  endtask

  always @(posedge clk) begin
    sample_t m;
    sample_t want;
    bit      has;
    if (!rst_n) begin
      clear_sequence();
      win_reg = CFG_W'(WINDOW_RESET);
      max_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_reg = cfg_window_size;
        clear_sequence();
      end
      if (in_valid && in_ready) begin
        advance_window(in_sample, in_first, has, m);
        if (has) max_expected = {max_expected, m};
      end
      if (out_valid && out_ready) begin
        if (max_expected.size() == 0) begin
          errors++;
          $display("%0t: window max expected none, got %0d", $time, out_window_max);
        end else begin
          want = max_expected[0];
          max_expected.delete(0);
          if (want !== out_window_max) begin
            errors++;
            $display("%0t: window max expected %0d, got %0d", $time, want, out_window_max);
          end
        end
      end
    end
    pending <= max_expected.size();
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the sliding window maximum filter: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
  import swm_pkg::*;

  localparam int LIMIT       = 1000000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef enum {PAT_NOISE, PAT_TIES, PAT_FALL, PAT_RISE, PAT_EXTREME} pattern_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  sample_t          in_sample = '0;
  logic             in_first = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  sample_t          out_window_max;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_window_size = '0;
  logic             calm = 1'b0;
  int               errors;
  int               pending;
  int               cycles = 0;
  int               stall = 0;

  sliding_window_maximum uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_first       (in_first),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_window_max (out_window_max),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_window_size(cfg_window_size)
  );

  swm_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_first       (in_first),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_window_max (out_window_max),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_window_size(cfg_window_size),
    .errors         (errors),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // toggles stretches without any idling
  always @(posedge clk) begin
    if ($urandom_range(0, 149) == 0) calm <= ~calm;
  end

  always @(posedge clk) begin
    if (stall > 0) begin
      out_ready <= 1'b0;
      stall <= stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall <= gap_len();
    end
  end

  task automatic send_item(input sample_t s, input logic f);
    int gap;
    in_valid  <= 1'b1;
    in_sample <= s;
    in_first  <= f;
    do @(posedge clk); while (!in_ready);
    gap = (!calm && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every expected maximum is out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    settle();
    cfg_valid       <= 1'b1;
    cfg_window_size <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one sequence of random shape; mostly long enough to yield results
  task automatic run_sequence(input int w, input bit flag_first, inout int count);
    int       len;
    pattern_t pat;
    sample_t  v;
    len = ($urandom_range(0, 99) < 80) ? $urandom_range(w, 3 * w + 20) : $urandom_range(1, w);
    pat = pattern_t'($urandom_range(0, 4));
    v = $urandom;
    for (int i = 0; i < len; i++) begin
      case (pat)
        PAT_NOISE: v = $urandom;
        PAT_TIES: begin
          v = $urandom_range(0, 7);
          v = v - 4;
        end
        PAT_FALL: v = v - $urandom_range(0, 3);
        PAT_RISE: v = v + $urandom_range(0, 3);
        default: begin
          case ($urandom_range(0, 3))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2: v = 0;
            default: v = -1;
          endcase
        end
      endcase
      send_item(v, (i == 0) && flag_first);
      count++;
    end
  endtask

  initial begin
    int phase_w;
    int span_w;
    int total;
    bit paused;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset window of three, no first flag since reset
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(1, 1'b0);
    // sequence shorter than the window
    send_item(5, 1'b1);
    send_item(5, 1'b0);
    // equal samples leaving the window
    send_item(7, 1'b1);
    repeat (4) send_item(7, 1'b0);
    send_item(-3, 1'b1);
    send_item(2, 1'b0);
    send_item(9, 1'b0);
    send_item(4, 1'b0);
    send_item(1, 1'b0);
    send_item(0, 1'b0);
    // zero window acts as one sample
    write_window(CFG_W'(0));
    send_item(-5, 1'b0);
    send_item(100, 1'b0);
    send_item(32'sh80000000, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_w = 64;
        1: phase_w = 127;
        2: phase_w = 1;
        3: phase_w = 2;
        4: phase_w = 65;
        default: phase_w = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 12)
                                                        : $urandom_range(0, 127);
      endcase
      write_window(CFG_W'(phase_w));
      span_w = (phase_w == 0) ? 1 : (phase_w > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : phase_w;
      total = 0;
      paused = 1'b0;
      while (total < PHASE_ITEMS) begin
        run_sequence(span_w, $urandom_range(0, 99) < 85, total);
        if (!paused && total >= PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    repeat (6) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_maximum.sv
test/swm_checker.sv
test/tb.sv
